>>> src/indexed_list_buffer_defines.svh
// Assertion macros shared by the indexed list buffer RTL.
// Needs no other file; the bodies are empty when SYNTH is defined.
`ifndef INDEXED_LIST_BUFFER_DEFINES_SVH
`define INDEXED_LIST_BUFFER_DEFINES_SVH

`ifndef SYNTH
// Check that a condition holds at every clock edge outside reset.
`define ILB_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");
// Check that a consequence holds in the same cycle as its trigger.
`define ILB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
// Check that a consequence holds in the cycle after its trigger.
`define ILB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ILB_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ILB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ILB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/ilb_pkg.sv
// Types and codes for the indexed list buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ilb_pkg;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_DRAIN,
        S_PUTVAL,
        S_RDWAIT,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    st_set;   // load the status code below
        t_status status;
        logic    wr_app;   // write the held word at the end of the list
        logic    wr_val;   // write the held word at the held index
        logic    rd_idx;   // read the store at the held index
        logic    rd_ptr;   // read the shift source and schedule its move
        logic    cap_rd;   // capture read data for the result
        logic    cnt_inc;
        logic    cnt_dec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic idx_bad;   // index not below count
        logic full;      // count at capacity
        logic ptr_last;  // shift source is the last one
        logic del_last;  // delete of the final word, nothing to move
    } t_stat;

endpackage

`default_nettype wire

>>> src/indexed_list_buffer.sv
// Top level of the indexed list buffer: ordered list of 64-bit words.
// Uses ilb_pkg, ilb_ctrl, ilb_datapath (with ilb_ram) and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_buffer_defines.svh"

// An ordered list of up to CAPACITY 64-bit words in a single-port-write RAM.
// A transaction is taken at a clock edge where start is high and busy is low;
// busy then stays high until its result has been shown. Each transaction gives
// exactly one result, present for one cycle with o_valid high; the receiver
// cannot stall it, so sample it on that cycle. Operations: append (0) adds at
// the end, insert (1) puts the word at i_index and moves later words up,
// delete (2) removes the word at i_index and moves later words down, read (3)
// returns the word at i_index. An index not below the count is rejected
// (status 1) with no change; append or a valid insert on a full list gives
// status 2. o_read_value is zero except for a successful read.
// The moves run one word per cycle through the RAM: one read and one write
// port, with the write of each moved word landing the cycle after its
// registered read. The word store needs no clearing after reset; of the
// list state, only the count is reset.

module indexed_list_buffer
    import ilb_pkg::*;
#(
    parameter  int CAPACITY = 64,
    localparam int AW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    i_operation,
    input  wire logic [AW-1:0] i_index,
    input  wire logic [63:0]   i_value,
    output logic               o_valid,
    output logic      [63:0]   o_read_value,
    output logic      [CW-1:0] o_count,
    output logic               o_empty_res,
    output logic      [1:0]    o_status
);

    t_cmd  cmd;
    t_stat stat;
    logic  load;

    // Sequence each transaction: decode, move words, write, report.
    ilb_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_stat (stat),
        .busy   (busy),
        .o_load (load),
        .o_cmd  (cmd),
        .o_valid(o_valid)
    );

    // Hold the transaction, the count and the word store; drive the result.
    ilb_datapath #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_operation (t_op'(i_operation)),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_read_value(o_read_value),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_status    (o_status)
    );

    // An accepted transaction always makes the block busy on the next cycle.
    `ILB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // The empty flag of a result agrees with its count.
    `ILB_ASSERT_IMPL(a_empty_match, i_clk, i_rst_n, o_valid, o_empty_res == (o_count == '0))

endmodule

`default_nettype wire

>>> src/ilb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module ilb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/ilb_ctrl.sv
// Controller state machine of the indexed list buffer.
// Uses ilb_pkg and the assertion macros; drives the datapath by commands.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_buffer_defines.svh"

module ilb_ctrl
    import ilb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_stat i_stat,
    output logic       busy,
    output logic       o_load,
    output t_cmd       o_cmd,
    output logic       o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                priority if (i_stat.op == OP_APPEND) begin
                    n_state = S_DONE;
                end else if (i_stat.idx_bad) begin
                    n_state = S_DONE;
                end else if (i_stat.op == OP_INSERT) begin
                    n_state = i_stat.full ? S_DONE : S_SHIFT;
                end else if (i_stat.op == OP_DELETE) begin
                    n_state = i_stat.del_last ? S_DONE : S_SHIFT;
                end else begin
                    n_state = S_RDWAIT;
                end
            end
            S_SHIFT: begin
                if (i_stat.ptr_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = (i_stat.op == OP_INSERT) ? S_PUTVAL : S_DONE;
            end
            S_PUTVAL: n_state = S_DONE;
            S_RDWAIT: n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd   = '0;
        o_load  = 1'b0;
        o_valid = 1'b0;
        busy    = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_load = start;
            end
            S_DECODE: begin
                o_cmd.st_set = 1'b1;
                o_cmd.status = ST_DONE;
                priority if (i_stat.op == OP_APPEND) begin
                    if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.wr_app  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end else if (i_stat.idx_bad) begin
                    o_cmd.status = ST_BAD_INDEX;
                end else if (i_stat.op == OP_INSERT) begin
                    if (i_stat.full) o_cmd.status = ST_FULL;
                end else if (i_stat.op == OP_DELETE) begin
                    if (i_stat.del_last) o_cmd.cnt_dec = 1'b1;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.rd_ptr = 1'b1;
            end
            S_DRAIN: begin
                if (i_stat.op == OP_DELETE) o_cmd.cnt_dec = 1'b1;
            end
            S_PUTVAL: begin
                o_cmd.wr_val  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            S_RDWAIT: begin
                o_cmd.cap_rd = 1'b1;
            end
            S_DONE: begin
                o_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // A result is always followed by an idle cycle that can take a new command.
    `ILB_ASSERT_NEXT(a_done_then_idle, i_clk, i_rst_n, o_valid, !busy)
    // The store is never written by two different commands at once.
    `ILB_ASSERT_ALWAYS(a_one_write_cmd, i_clk, i_rst_n, !(o_cmd.wr_app && o_cmd.wr_val))

endmodule

`default_nettype wire

>>> src/ilb_datapath.sv
// Datapath of the indexed list buffer: word store, count, shift pointer, result.
// Uses ilb_pkg, ilb_ram and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_buffer_defines.svh"

module ilb_datapath
    import ilb_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire t_op           i_operation,
    input  wire logic [AW-1:0] i_index,
    input  wire logic [63:0]   i_value,
    input  wire t_cmd          i_cmd,
    output t_stat              o_stat,
    output logic      [63:0]   o_read_value,
    output logic      [CW-1:0] o_count,
    output logic               o_empty_res,
    output logic      [1:0]    o_status
);

    t_op           r_op;
    logic [AW-1:0] r_idx;
    logic [63:0]   r_val;
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_cnt;
    t_status       r_status;
    logic [63:0]   r_rdv;
    logic          r_wpend;
    logic [AW-1:0] r_waddr;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] idx_ext;
    logic          we;
    logic [AW-1:0] waddr;
    logic [63:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [63:0]   rdata;

    assign cnt_m1  = r_cnt - 1'b1;
    assign idx_ext = CW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_wpend <= i_cmd.rd_ptr;
            priority if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op  <= i_operation;
            r_idx <= i_index;
            r_val <= i_value;
            r_rdv <= '0;
            // Insert moves from the top down, delete from just above the gap up.
            r_ptr <= (i_operation == OP_DELETE) ? i_index + 1'b1 : AW'(cnt_m1);
        end else begin
            if (i_cmd.rd_ptr) begin
                r_ptr   <= (r_op == OP_INSERT) ? r_ptr - 1'b1 : r_ptr + 1'b1;
                r_waddr <= (r_op == OP_INSERT) ? r_ptr + 1'b1 : r_ptr - 1'b1;
            end
            if (i_cmd.cap_rd) r_rdv <= rdata;
        end
        if (i_cmd.st_set) r_status <= i_cmd.status;
    end

    // Write port: a pending move has priority, it lands in the cycle after its read.
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = r_val;
        priority if (r_wpend) begin
            we    = 1'b1;
            waddr = r_waddr;
            wdata = rdata;
        end else if (i_cmd.wr_val) begin
            we    = 1'b1;
        end else if (i_cmd.wr_app) begin
            we    = 1'b1;
            waddr = AW'(r_cnt);
        end
    end

    assign re    = i_cmd.rd_ptr | i_cmd.rd_idx;
    assign raddr = i_cmd.rd_ptr ? r_ptr : r_idx;

    ilb_ram #(
        .WIDTH(64),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_stat.op       = r_op;
    assign o_stat.idx_bad  = (idx_ext >= r_cnt);
    assign o_stat.full     = (r_cnt == CW'(CAPACITY));
    assign o_stat.ptr_last = (r_op == OP_INSERT) ? (r_ptr == r_idx) : (r_ptr == AW'(cnt_m1));
    assign o_stat.del_last = (idx_ext + 1'b1 == r_cnt);

    assign o_read_value = r_rdv;
    assign o_count      = r_cnt;
    assign o_empty_res  = (r_cnt == '0);
    assign o_status     = r_status;

    // The count never passes the capacity.
    `ILB_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(CAPACITY))
    // A pending move never collides with a direct write of the held word.
    `ILB_ASSERT_IMPL(a_wr_exclusive, i_clk, i_rst_n, r_wpend, !i_cmd.wr_val && !i_cmd.wr_app)

endmodule

`default_nettype wire

>>> verif/tb_indexed_list_buffer.sv
// Self-checking testbench for indexed_list_buffer: a directed table followed by random traffic.
// A predictor mirrors the list and checks every result. Depends on ilb_pkg and the RTL in src.
`timescale 1ns / 1ps

module tb_indexed_list_buffer;
    import ilb_pkg::*;

    localparam int CAP          = 64;
    localparam int CW           = $clog2(CAP + 1);
    localparam int RANDOM_ITEMS = 1400;
    // The longest transaction is an insert at position 0 of a 63-word list.
    localparam int DRAIN_TAIL   = 80;
    localparam int CYCLE_LIMIT  = 1000000;

    // One result as the block reports it.
    typedef struct packed {
        logic [63:0]   word;
        logic [CW-1:0] count;
        logic          empty;
        t_status       status;
    } t_list_result;

    // One row of the directed table. Repeat the row reps times, adding the repeat number to
    // the word. Where typed is set, the expected result is the one in the row.
    typedef struct {
        t_op          op;
        logic [5:0]   idx;
        logic [63:0]  word;
        int           reps;
        bit           typed;
        t_list_result want;
    } t_vector;

    typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} t_mode;

    localparam t_list_result PREDICTED = '0;
    localparam logic [63:0]  ONES      = {64{1'b1}};

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [1:0]    i_operation;
    logic [5:0]    i_index;
    logic [63:0]   i_value;
    logic          o_valid;
    logic [63:0]   o_read_value;
    logic [CW-1:0] o_count;
    logic          o_empty_res;
    logic [1:0]    o_status;

    // Shadow copy of the list, kept in step with each accepted transaction.
    logic [63:0]  list_words [CAP];
    int           list_len;
    t_list_result pending_results [$];
    t_list_result oldest;
    int           errors;
    int           cycle_count;

    // Walk the special cases: an empty list, the last position, a full list and a
    // list emptied again by deletes.
    t_vector directed_rows [25] = '{
        '{OP_READ,   6'd0,  64'd0, 1, 1'b1, '{64'd0, 7'd0,  1'b1, ST_BAD_INDEX}},
        '{OP_DELETE, 6'd63, 64'd0, 1, 1'b1, '{64'd0, 7'd0,  1'b1, ST_BAD_INDEX}},
        '{OP_INSERT, 6'd0,  ONES,  1, 1'b1, '{64'd0, 7'd0,  1'b1, ST_BAD_INDEX}},
        '{OP_APPEND, 6'd63, ONES,  1, 1'b1, '{64'd0, 7'd1,  1'b0, ST_DONE}},
        '{OP_READ,   6'd0,  64'd0, 1, 1'b1, '{ONES,  7'd1,  1'b0, ST_DONE}},
        '{OP_APPEND, 6'd0,  64'd0, 1, 1'b1, '{64'd0, 7'd2,  1'b0, ST_DONE}},
        '{OP_READ,   6'd1,  ONES,  1, 1'b1, '{64'd0, 7'd2,  1'b0, ST_DONE}},
        '{OP_READ,   6'd2,  64'd0, 1, 1'b1, '{64'd0, 7'd2,  1'b0, ST_BAD_INDEX}},
        '{OP_INSERT, 6'd0,  64'h5555_5555_5555_5555, 1, 1'b0, PREDICTED},
        '{OP_INSERT, 6'd2,  64'haaaa_aaaa_aaaa_aaaa, 1, 1'b0, PREDICTED},
        '{OP_READ,   6'd0,  64'd0, 1, 1'b0, PREDICTED},
        '{OP_READ,   6'd3,  64'd0, 1, 1'b0, PREDICTED},
        '{OP_DELETE, 6'd3,  64'd0, 1, 1'b0, PREDICTED},
        '{OP_DELETE, 6'd0,  64'd0, 1, 1'b0, PREDICTED},
        '{OP_APPEND, 6'd0,  64'h0123_4567_89ab_cdef, 62, 1'b0, PREDICTED},
        '{OP_APPEND, 6'd0,  64'd1, 1, 1'b1, '{64'd0, 7'd64, 1'b0, ST_FULL}},
        '{OP_INSERT, 6'd63, 64'd2, 1, 1'b1, '{64'd0, 7'd64, 1'b0, ST_FULL}},
        '{OP_INSERT, 6'd0,  64'd3, 1, 1'b1, '{64'd0, 7'd64, 1'b0, ST_FULL}},
        '{OP_READ,   6'd63, 64'd0, 1, 1'b0, PREDICTED},
        '{OP_DELETE, 6'd63, 64'd0, 1, 1'b1, '{64'd0, 7'd63, 1'b0, ST_DONE}},
        '{OP_INSERT, 6'd63, ONES,  1, 1'b1, '{64'd0, 7'd63, 1'b0, ST_BAD_INDEX}},
        '{OP_READ,   6'd63, 64'd0, 1, 1'b1, '{64'd0, 7'd63, 1'b0, ST_BAD_INDEX}},
        '{OP_INSERT, 6'd62, ONES,  1, 1'b0, PREDICTED},
        '{OP_DELETE, 6'd0,  64'd0, 63, 1'b0, PREDICTED},
        '{OP_DELETE, 6'd0,  64'd0, 1, 1'b1, '{64'd0, 7'd0,  1'b1, ST_DONE}}
    };

    indexed_list_buffer #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_read_value(o_read_value),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_status    (o_status)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the shadow list and return the result it must produce.
    // The index check comes before the full check, so a bad insert on a full list
    // reports the bad index.
    function automatic t_list_result apply_list_op(t_op op, logic [5:0] idx,
                                                   logic [63:0] word);
        t_list_result res;
        int           pos;
        res.word   = '0;
        res.status = ST_DONE;
        if (op == OP_APPEND) begin
            if (list_len >= CAP) begin
                res.status = ST_FULL;
            end else begin
                list_words[list_len] = word;
                list_len++;
            end
        end else if (int'(idx) >= list_len) begin
            res.status = ST_BAD_INDEX;
        end else begin
            case (op)
                OP_INSERT: begin
                    if (list_len >= CAP) begin
                        res.status = ST_FULL;
                    end else begin
                        // Open a gap at idx by moving the tail up one place.
                        for (pos = list_len; pos > int'(idx); pos--)
                            list_words[pos] = list_words[pos - 1];
                        list_words[idx] = word;
                        list_len++;
                    end
                end
                OP_DELETE: begin
                    // Close the gap by moving the tail down one place.
                    for (pos = int'(idx); pos + 1 < list_len; pos++)
                        list_words[pos] = list_words[pos + 1];
                    list_len--;
                end
                default: begin
                    res.word = list_words[idx];
                end
            endcase
        end
        res.count = list_len[CW-1:0];
        res.empty = (list_len == 0);
        return res;
    endfunction

    // Idle gap before the next transaction: mostly none or short, now and then long.
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Index that mostly hits a valid position, sometimes the first invalid one, else any.
    function automatic logic [5:0] pick_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (list_len > 0 && roll < 85)
            return 6'($urandom_range(0, list_len - 1));
        else if (roll < 92)
            return (list_len > 63) ? 6'd63 : 6'(list_len);
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [63:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 64'd0;
        else if (roll < 10)
            return ONES;
        return {$urandom, $urandom};
    endfunction

    // Drop start for some cycles; with drain set, also hold off until every
    // outstanding result has come back.
    task automatic pause_sender(int cycles, bit drain);
        if (drain && cycles == 0)
            cycles = 1;
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
            while (drain && pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    // Present one transaction and hold it until an edge with busy low takes it.
    // Start stays high on return, so a back-to-back transaction keeps it up.
    task automatic issue(t_op op, logic [5:0] idx, logic [63:0] word, bit typed,
                         t_list_result typed_res);
        t_list_result predicted;
        start       <= 1'b1;
        i_operation <= op;
        i_index     <= idx;
        i_value     <= word;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = apply_list_op(op, idx, word);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Check each result against the oldest outstanding expectation. The receiver
    // cannot stall, so take the result on the one cycle that o_valid marks.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: count %0d status %0d",
                         $time, o_count, o_status);
                errors++;
            end else begin
                oldest = pending_results.pop_front();
                report_field("read_value", oldest.word, o_read_value);
                report_field("count", 64'(oldest.count), 64'(o_count));
                report_field("empty_res", 64'(oldest.empty), 64'(o_empty_res));
                report_field("status", 64'(oldest.status), 64'(o_status));
            end
        end
    end

    // Guard against a hang: end the run well past the slowest correct finish.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int           rep;
        int           k;
        int           burst;
        int           random_done;
        int           roll;
        bit           quiet;
        bit           drained_once;
        t_mode        mode;
        t_op          op;
        logic [5:0]   idx;

        errors       = 0;
        list_len     = 0;
        random_done  = 0;
        drained_once = 1'b0;

        // Drive every input to a known value and hold reset.
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_APPEND;
        i_index     <= '0;
        i_value     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (directed_rows[n]) begin
            for (rep = 0; rep < directed_rows[n].reps; rep++) begin
                pause_sender(next_gap(), 1'b0);
                issue(directed_rows[n].op, directed_rows[n].idx,
                      directed_rows[n].word + 64'(rep), directed_rows[n].typed,
                      directed_rows[n].want);
            end
        end

        // Random part, in bursts that lean toward growing, shrinking or mixing the
        // list, plus noise bursts with any index. Some bursts run without idling.
        while (random_done < RANDOM_ITEMS) begin
            mode  = t_mode'($urandom_range(0, 3));
            burst = $urandom_range(20, 120);
            quiet = ($urandom_range(0, 3) == 0);

            // Stop sending until the block has returned everything outstanding.
            if ((!drained_once && random_done >= RANDOM_ITEMS / 2)
                    || $urandom_range(0, 9) == 0) begin
                pause_sender(1, 1'b1);
                drained_once = 1'b1;
            end

            for (k = 0; k < burst && random_done < RANDOM_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_GROW:
                        op = (roll < 45) ? OP_APPEND : (roll < 85) ? OP_INSERT :
                             (roll < 95) ? OP_READ : OP_DELETE;
                    MODE_SHRINK:
                        op = (roll < 10) ? OP_APPEND : (roll < 20) ? OP_INSERT :
                             (roll < 40) ? OP_READ : OP_DELETE;
                    MODE_MIXED:
                        op = (roll < 25) ? OP_APPEND : (roll < 50) ? OP_INSERT :
                             (roll < 75) ? OP_DELETE : OP_READ;
                    default:
                        op = t_op'($urandom_range(0, 3));
                endcase
                idx = (mode == MODE_NOISE) ? 6'($urandom_range(0, 63)) : pick_index();
                pause_sender(quiet ? 0 : next_gap(), 1'b0);
                issue(op, idx, pick_word(), 1'b0, PREDICTED);
                random_done++;
            end
        end

        // Wait for the last results, then allow a full transaction's worth of cycles
        // for anything stray.
        pause_sender(1, 1'b1);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/ilb_pkg.sv
src/ilb_ram.sv
src/ilb_ctrl.sv
src/ilb_datapath.sv
src/indexed_list_buffer.sv
verif/tb_indexed_list_buffer.sv
